FILE: hw/rtl/ealu_pkg.sv
// ----------------------------------------------------------------------------
// ealu_pkg
// Shared types and constants for the 8-bit ALU with flags: operation codes,
// the flag set, the request and the result records.
// ----------------------------------------------------------------------------
package ealu_pkg;

  // Operation codes carried in the kind field.
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_ADD16 = 5'd10,
    OP_ADDSP = 5'd11,
    OP_INC16 = 5'd12,
    OP_DEC16 = 5'd13,
    OP_DAA   = 5'd14,
    OP_CCF   = 5'd15,
    OP_SCF   = 5'd16,
    OP_CPL   = 5'd17
  } op_t;

  // Decimal adjust steps and limits.
  localparam logic [7:0] DaaLowAdj  = 8'h06;
  localparam logic [7:0] DaaHighAdj = 8'h60;
  localparam logic [3:0] DaaLowMax  = 4'h9;
  localparam logic [7:0] DaaHighMax = 8'h99;

  // Stream widths.
  localparam int InDataW  = 48;
  localparam int InUserW  = 5;
  localparam int OutDataW = 24;

  typedef struct packed {
    logic zero;
    logic subtract;
    logic half;
    logic carry;
  } flags_t;

  typedef struct packed {
    op_t         kind;
    logic [7:0]  acc_value;
    logic [7:0]  operand_byte;
    logic [15:0] wide_dest;
    logic [15:0] wide_operand;
  } req_t;

  typedef struct packed {
    logic [15:0] result;
    flags_t      flags;
  } res_t;

endpackage

FILE: hw/rtl/eight_bit_alu_with_flags_unit.sv
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_unit
// 8-bit ALU with zero, subtract, half-carry and carry flags, including the
// 16-bit adds, stack pointer offset and decimal adjust.
//
//   Channel  Direction  tdata                                 tuser
//   s_*      in         acc, operand, wide_dest, wide_operand kind
//   m_*      out        result, zero, subtract, half, carry   -
//
// One request per cycle unless the master stalls: each request waits in the
// input register, then the execute logic writes the result register and the
// flag register together, so the next request already sees the updated flags.
// Reset clears both valid bits and all four flags. A stalled master holds
// the result; the input register keeps accepting until it holds one request.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // acc_value [7:0], operand_byte [15:8], wide_dest [31:16], wide_operand [47:32]
  input  logic [ealu_pkg::InDataW-1:0]    s_tdata,
  // kind [4:0]
  input  logic [ealu_pkg::InUserW-1:0]    s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // result [15:0], zero_out [16], subtract_out [17], half_out [18],
  // carry_out [19], zero fill [23:20]
  output logic [ealu_pkg::OutDataW-1:0]   m_tdata
);

  ealu_pkg::req_t   req;
  ealu_pkg::res_t   res;
  ealu_pkg::flags_t flags;
  logic             req_valid;
  logic             advance;

  ealu_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .advance  (advance),
    .valid    (req_valid),
    .req      (req)
  );

  ealu_exec u_exec (
    .req   (req),
    .flags (flags),
    .res   (res)
  );

  ealu_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_valid),
    .res      (res),
    .advance  (advance),
    .flags    (flags),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

FILE: hw/rtl/ealu_in_stage.sv
// ----------------------------------------------------------------------------
// ealu_in_stage
// Input register: captures one request from the slave stream and holds it
// until the execute step moves it into the result register.
// ----------------------------------------------------------------------------
module ealu_in_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // acc_value [7:0], operand_byte [15:8], wide_dest [31:16], wide_operand [47:32]
  input  logic [ealu_pkg::InDataW-1:0]   s_tdata,
  // kind [4:0]
  input  logic [ealu_pkg::InUserW-1:0]   s_tuser,
  input  logic                           advance,
  output logic                           valid,
  output ealu_pkg::req_t                 req
);

  logic valid_next;

  // The slot is free when empty or when its request leaves this cycle.
  assign s_tready = !valid || advance;

  always_comb begin
    valid_next = valid;
    if (s_tready) begin
      valid_next = s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req.kind         <= ealu_pkg::op_t'(s_tuser);
      req.acc_value    <= s_tdata[7:0];
      req.operand_byte <= s_tdata[15:8];
      req.wide_dest    <= s_tdata[31:16];
      req.wide_operand <= s_tdata[47:32];
    end
  end

endmodule

FILE: hw/rtl/ealu_exec.sv
// ----------------------------------------------------------------------------
// ealu_exec
// Execute logic: computes the result and the new flags of one request from
// its operands and the current flags.
// ----------------------------------------------------------------------------
module ealu_exec (
  input  ealu_pkg::req_t   req,
  input  ealu_pkg::flags_t flags,
  output ealu_pkg::res_t   res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic [8:0]  add9;
  logic [4:0]  add_low;
  logic [8:0]  sub9;
  logic [4:0]  sub_low;
  logic [16:0] add17;
  logic [12:0] add_low13;
  logic [15:0] sp_sum;
  logic [8:0]  sp_low9;
  logic [4:0]  sp_low5;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_adj;
  logic [7:0]  daa_res;
  logic [7:0]  r8;
  logic        use_r8;

  assign a = req.acc_value;
  assign b = req.operand_byte;

  // The carry flag enters only the with-carry forms.
  assign cin = ((req.kind == ealu_pkg::OP_ADC) || (req.kind == ealu_pkg::OP_SBC))
               ? flags.carry : 1'b0;

  // Shared byte adder and subtractor with nibble carries.
  assign add9    = {1'b0, a} + {1'b0, b} + {8'd0, cin};
  assign add_low = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
  assign sub9    = {1'b0, a} - {1'b0, b} - {8'd0, cin};
  assign sub_low = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

  // Word add and stack pointer offset.
  assign add17     = {1'b0, req.wide_dest} + {1'b0, req.wide_operand};
  assign add_low13 = {1'b0, req.wide_dest[11:0]} + {1'b0, req.wide_operand[11:0]};
  assign sp_sum    = req.wide_dest + {{8{b[7]}}, b};
  assign sp_low9   = {1'b0, req.wide_dest[7:0]} + {1'b0, b};
  assign sp_low5   = {1'b0, req.wide_dest[3:0]} + {1'b0, b[3:0]};

  // Decimal adjust: after a subtraction only the flags choose the steps.
  always_comb begin
    if (flags.subtract) begin
      daa_lo = flags.half;
      daa_hi = flags.carry;
    end else begin
      daa_lo = flags.half || (a[3:0] > ealu_pkg::DaaLowMax);
      daa_hi = flags.carry || (a > ealu_pkg::DaaHighMax);
    end
    daa_adj = (daa_lo ? ealu_pkg::DaaLowAdj : 8'h00) |
              (daa_hi ? ealu_pkg::DaaHighAdj : 8'h00);
    daa_res = flags.subtract ? (a - daa_adj) : (a + daa_adj);
  end

  // Operation select.
  always_comb begin
    res.flags  = flags;
    r8         = 8'h00;
    use_r8     = 1'b1;
    res.result = 16'h0000;
    case (req.kind)
      ealu_pkg::OP_ADD, ealu_pkg::OP_ADC: begin
        r8                = add9[7:0];
        res.flags.zero     = (r8 == 8'h00);
        res.flags.subtract = 1'b0;
        res.flags.half     = add_low[4];
        res.flags.carry    = add9[8];
      end
      ealu_pkg::OP_SUB, ealu_pkg::OP_SBC, ealu_pkg::OP_CP: begin
        r8                = (req.kind == ealu_pkg::OP_CP) ? a : sub9[7:0];
        res.flags.zero     = (sub9[7:0] == 8'h00);
        res.flags.subtract = 1'b1;
        res.flags.half     = sub_low[4];
        res.flags.carry    = sub9[8];
      end
      ealu_pkg::OP_AND, ealu_pkg::OP_OR, ealu_pkg::OP_XOR: begin
        if (req.kind == ealu_pkg::OP_AND) begin
          r8 = a & b;
        end else if (req.kind == ealu_pkg::OP_OR) begin
          r8 = a | b;
        end else begin
          r8 = a ^ b;
        end
        res.flags.zero     = (r8 == 8'h00);
        res.flags.subtract = 1'b0;
        res.flags.half     = (req.kind == ealu_pkg::OP_AND);
        res.flags.carry    = 1'b0;
      end
      ealu_pkg::OP_INC: begin
        r8                = a + 8'd1;
        res.flags.zero     = (r8 == 8'h00);
        res.flags.subtract = 1'b0;
        res.flags.half     = (a[3:0] == 4'hF);
      end
      ealu_pkg::OP_DEC: begin
        r8                = a - 8'd1;
        res.flags.zero     = (r8 == 8'h00);
        res.flags.subtract = 1'b1;
        res.flags.half     = (a[3:0] == 4'h0);
      end
      ealu_pkg::OP_ADD16: begin
        use_r8             = 1'b0;
        res.result         = add17[15:0];
        res.flags.subtract = 1'b0;
        res.flags.half     = add_low13[12];
        res.flags.carry    = add17[16];
      end
      ealu_pkg::OP_ADDSP: begin
        use_r8             = 1'b0;
        res.result         = sp_sum;
        res.flags.zero     = 1'b0;
        res.flags.subtract = 1'b0;
        res.flags.half     = sp_low5[4];
        res.flags.carry    = sp_low9[8];
      end
      ealu_pkg::OP_INC16: begin
        use_r8     = 1'b0;
        res.result = req.wide_dest + 16'd1;
      end
      ealu_pkg::OP_DEC16: begin
        use_r8     = 1'b0;
        res.result = req.wide_dest - 16'd1;
      end
      ealu_pkg::OP_DAA: begin
        r8             = daa_res;
        res.flags.zero = (r8 == 8'h00);
        res.flags.half = 1'b0;
        if (!flags.subtract) begin
          res.flags.carry = daa_hi;
        end
      end
      ealu_pkg::OP_CCF, ealu_pkg::OP_SCF: begin
        res.flags.subtract = 1'b0;
        res.flags.half     = 1'b0;
        res.flags.carry    = (req.kind == ealu_pkg::OP_SCF) || !flags.carry;
        r8                 = {7'd0, res.flags.carry};
      end
      ealu_pkg::OP_CPL: begin
        r8                 = ~a;
        res.flags.subtract = 1'b1;
        res.flags.half     = 1'b1;
      end
      default: begin
        // Unused codes leave the flags alone and return zero.
        r8 = 8'h00;
      end
    endcase
    if (use_r8) begin
      res.result = {8'h00, r8};
    end
  end

endmodule

FILE: hw/rtl/ealu_out_stage.sv
// ----------------------------------------------------------------------------
// ealu_out_stage
// Result register and flag register: takes each executed request, updates
// the flags and presents the result on the master stream.
// ----------------------------------------------------------------------------
module ealu_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  ealu_pkg::res_t                  res,
  output logic                            advance,
  output ealu_pkg::flags_t                flags,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // result [15:0], zero_out [16], subtract_out [17], half_out [18],
  // carry_out [19], zero fill [23:20]
  output logic [ealu_pkg::OutDataW-1:0]   m_tdata
);

  ealu_pkg::res_t out_reg;
  logic           m_tvalid_next;

  // A request moves on when the result slot is empty or being emptied.
  assign advance = in_valid && (!m_tvalid || m_tready);

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (!m_tvalid || m_tready) begin
      m_tvalid_next = in_valid;
    end
  end

  // Flags and handshake state.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      flags    <= '0;
    end else begin
      m_tvalid <= m_tvalid_next;
      if (advance) begin
        flags <= res.flags;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {4'h0, out_reg.flags.carry, out_reg.flags.half,
                    out_reg.flags.subtract, out_reg.flags.zero, out_reg.result};

endmodule
